### design/cbp_pkg.sv
package cbp_pkg;

  // row geometry
  localparam int ROW_LEN    = 8;
  localparam int INIT_TERMS = 4;
  localparam int TERMS      = (INIT_TERMS < ROW_LEN) ? INIT_TERMS : ROW_LEN;
  localparam int IDX_W      = $clog2(ROW_LEN);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_LEN - 1);
  localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(ROW_LEN - 2);
  localparam logic [IDX_W-1:0] ANTE_IDX = IDX_W'(ROW_LEN - 3);
  localparam logic [IDX_W-1:0] TERM_END = IDX_W'(TERMS - 1);

  // number formats
  localparam int SMP_W = 20;          // sample and coefficient, q10
  localparam int FRAC  = 20;          // internal fraction bits
  localparam int QSH   = FRAC - 10;   // q10 to q20 shift
  localparam int CW    = 34;          // internal coefficient width
  localparam int MA_W  = CW + 2;      // multiplier data operand
  localparam int MB_W  = 22;          // multiplier constant operand
  localparam int PR_W  = MA_W + MB_W;

  // pole z1 = sqrt(3)-2 and z1/(z1^2-1), both q20
  localparam logic signed [MB_W-1:0] Z1_Q = -MB_W'(280965);
  localparam logic signed [MB_W-1:0] ZA_Q = MB_W'(302698);
  localparam logic signed [PR_W-1:0] MUL_RND = PR_W'(1) <<< (FRAC - 1);

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_INIT,
    ST_CAUSAL,
    ST_ACS_A,
    ST_ACS_B,
    ST_ANTI,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic signed [CW-1:0] value;
  } emit_t;

  // q20 product, rounded half up
  function automatic logic signed [CW-1:0] mulq(input logic signed [MA_W-1:0] a,
                                                input logic signed [MB_W-1:0] b);
    logic signed [PR_W-1:0] p;
    p = PR_W'(a) * PR_W'(b);
    p = p + MUL_RND;
    return CW'(p >>> FRAC);
  endfunction

  // z1^k built by repeated rounded products, zero past the start sum
  function automatic logic signed [MB_W-1:0] pow_z1(input int k);
    longint p;
    p = longint'(1) <<< FRAC;
    for (int i = 0; i < k; i++) begin
      p = (p * longint'(Z1_Q) + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    end
    if (k >= TERMS) begin
      p = 0;
    end
    return MB_W'(p);
  endfunction

endpackage

### design/cbp_ram.sv
module cbp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/cbp_engine.sv
module cbp_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [cbp_pkg::SMP_W-1:0]  sample,
  output logic                              busy,
  output cbp_pkg::emit_t                    emit
);

  localparam int IDX_W = cbp_pkg::IDX_W;
  localparam int CW    = cbp_pkg::CW;
  localparam int MA_W  = cbp_pkg::MA_W;
  localparam int MB_W  = cbp_pkg::MB_W;
  localparam int SMP_W = cbp_pkg::SMP_W;
  localparam int QSH   = cbp_pkg::QSH;

  cbp_pkg::state_t state, state_next;

  logic [IDX_W-1:0] count, count_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] dly_idx, dly_idx_next;
  logic             pend, pend_next;

  logic signed [CW-1:0] cp, cp_next;
  logic signed [CW-1:0] cp_prev, cp_prev_next;
  logic signed [CW-1:0] cm, cm_next;

  logic                    s_we;
  logic [SMP_W-1:0]        s_rdata;
  logic signed [CW-1:0]    s_q;

  logic                    c_we;
  logic [IDX_W-1:0]        c_waddr;
  logic [IDX_W-1:0]        c_raddr;
  logic signed [CW-1:0]    c_wdata;
  logic [CW-1:0]           c_rdata;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [CW-1:0]    mul_q;

  logic signed [MB_W-1:0]  pow_tab [cbp_pkg::ROW_LEN];

  for (genvar g = 0; g < cbp_pkg::ROW_LEN; g++) begin : g_pow
    assign pow_tab[g] = cbp_pkg::pow_z1(g);
  end

  // row samples
  cbp_ram #(
    .WIDTH (SMP_W),
    .DEPTH (cbp_pkg::ROW_LEN)
  ) u_smp_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (count),
    .wdata (sample),
    .raddr (rd_idx),
    .rdata (s_rdata)
  );

  // causal values, overwritten in place by anticausal values
  cbp_ram #(
    .WIDTH (CW),
    .DEPTH (cbp_pkg::ROW_LEN)
  ) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign s_q   = {{(CW-SMP_W-QSH){s_rdata[SMP_W-1]}}, s_rdata, {QSH{1'b0}}};
  assign mul_q = cbp_pkg::mulq(mul_a, mul_b);
  assign busy  = (state != cbp_pkg::ST_COLLECT);
  assign s_we  = start && (state == cbp_pkg::ST_COLLECT);

  assign emit.valid = (state == cbp_pkg::ST_EMIT) && pend;
  assign emit.last  = (dly_idx == cbp_pkg::LAST_IDX);
  assign emit.value = c_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cbp_pkg::ST_COLLECT;
      count   <= '0;
      rd_idx  <= '0;
      dly_idx <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_idx  <= rd_idx_next;
      dly_idx <= dly_idx_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cp      <= cp_next;
    cp_prev <= cp_prev_next;
    cm      <= cm_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    rd_idx_next  = rd_idx;
    dly_idx_next = dly_idx;
    pend_next    = pend;
    cp_next      = cp;
    cp_prev_next = cp_prev;
    cm_next      = cm;
    c_we         = 1'b0;
    c_waddr      = dly_idx;
    c_wdata      = mul_q;
    c_raddr      = rd_idx;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      cbp_pkg::ST_COLLECT: begin
        if (s_we) begin
          if (count == cbp_pkg::LAST_IDX) begin
            count_next  = '0;
            state_next  = cbp_pkg::ST_INIT;
            rd_idx_next = '0;
            pend_next   = 1'b0;
            cp_next     = '0;
          end else begin
            count_next = IDX_W'(count + 1'b1);
          end
        end
      end
      cbp_pkg::ST_INIT: begin
        mul_a        = MA_W'(s_q);
        mul_b        = pow_tab[dly_idx];
        pend_next    = 1'b1;
        dly_idx_next = rd_idx;
        rd_idx_next  = IDX_W'(rd_idx + 1'b1);
        if (pend) begin
          cp_next = cp + mul_q;
          if (dly_idx == cbp_pkg::TERM_END) begin
            state_next  = cbp_pkg::ST_CAUSAL;
            rd_idx_next = IDX_W'(1);
            pend_next   = 1'b0;
          end
        end
      end
      cbp_pkg::ST_CAUSAL: begin
        mul_a        = MA_W'(cp);
        mul_b        = cbp_pkg::Z1_Q;
        pend_next    = 1'b1;
        dly_idx_next = rd_idx;
        rd_idx_next  = IDX_W'(rd_idx + 1'b1);
        c_we         = 1'b1;
        if (!pend) begin
          // causal start value goes to entry zero
          c_waddr = '0;
          c_wdata = cp;
        end else begin
          cp_next      = s_q + mul_q;
          cp_prev_next = cp;
          c_wdata      = cp_next;
          if (dly_idx == cbp_pkg::LAST_IDX) begin
            state_next = cbp_pkg::ST_ACS_A;
            pend_next  = 1'b0;
          end
        end
      end
      cbp_pkg::ST_ACS_A: begin
        mul_a      = MA_W'(cp_prev);
        mul_b      = cbp_pkg::Z1_Q;
        cm_next    = cp + mul_q;
        state_next = cbp_pkg::ST_ACS_B;
      end
      cbp_pkg::ST_ACS_B: begin
        mul_a        = MA_W'(cm);
        mul_b        = cbp_pkg::ZA_Q;
        cm_next      = mul_q;
        c_we         = 1'b1;
        c_waddr      = cbp_pkg::LAST_IDX;
        c_raddr      = cbp_pkg::PEN_IDX;
        dly_idx_next = cbp_pkg::PEN_IDX;
        rd_idx_next  = cbp_pkg::ANTE_IDX;
        pend_next    = 1'b1;
        state_next   = cbp_pkg::ST_ANTI;
      end
      cbp_pkg::ST_ANTI: begin
        mul_a        = MA_W'(cm) - MA_W'($signed(c_rdata));
        mul_b        = cbp_pkg::Z1_Q;
        cm_next      = mul_q;
        c_we         = 1'b1;
        dly_idx_next = rd_idx;
        rd_idx_next  = IDX_W'(rd_idx - 1'b1);
        pend_next    = 1'b1;
        if (dly_idx == '0) begin
          state_next  = cbp_pkg::ST_EMIT;
          rd_idx_next = '0;
          pend_next   = 1'b0;
        end
      end
      cbp_pkg::ST_EMIT: begin
        dly_idx_next = rd_idx;
        rd_idx_next  = IDX_W'(rd_idx + 1'b1);
        pend_next    = 1'b1;
        if (pend && (dly_idx == cbp_pkg::LAST_IDX)) begin
          state_next = cbp_pkg::ST_COLLECT;
          pend_next  = 1'b0;
        end
      end
      default: begin
        state_next = cbp_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

### design/cbp_out_stage.sv
module cbp_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  cbp_pkg::emit_t                    emit,
  output logic                              strobe,
  output logic signed [cbp_pkg::SMP_W-1:0]  coefficient,
  output logic                              last_in_row
);

  localparam int SC_W  = cbp_pkg::CW + 4;
  localparam int SMP_W = cbp_pkg::SMP_W;
  localparam int QSH   = cbp_pkg::QSH;

  localparam logic signed [SC_W-1:0] SAT_HI = SC_W'((64'sd1 <<< (SMP_W - 1)) - 64'sd1);
  localparam logic signed [SC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SC_W-1:0] RND    = SC_W'(1) <<< (QSH - 1);

  logic signed [SC_W-1:0]  v_ext;
  logic signed [SC_W-1:0]  scaled;
  logic signed [SC_W-1:0]  shifted;
  logic signed [SMP_W-1:0] sat;

  // times six, round to q10, clamp
  always_comb begin
    v_ext   = SC_W'(emit.value);
    scaled  = (v_ext <<< 2) + (v_ext <<< 1) + RND;
    shifted = scaled >>> QSH;
    if (shifted > SAT_HI) begin
      sat = SAT_HI[SMP_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[SMP_W-1:0];
    end else begin
      sat = shifted[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    coefficient <= sat;
    last_in_row <= emit.last;
  end

endmodule

### design/cubic_bspline_prefilter_row_top.sv
// cubic b-spline prefilter, one row at a time
//
// input: a transfer happens on a clock edge with start high and busy low;
// sample is a signed q10 value. one sample per cycle is taken while a row
// is being gathered, so a row of ROW_LEN samples can arrive back to back
// output: each coefficient is shown for exactly one cycle with strobe high,
// in row order, the final one with last_in_row set; the receiver cannot
// stall, so there is no backpressure and nothing is held
// after the last sample of a row, busy rises and stays high through the
// causal start sum over the first TERMS samples, then the causal pass, the
// anticausal pass and the read-out each walk the row held in memory; the
// single registered read port of each memory sets the pace of one entry
// per cycle
// the first strobe comes once the anticausal pass is through, the others follow
// on consecutive cycles; busy falls as the final coefficient is shown, so the
// next row may start at once
// reset (rst, synchronous) empties the row being gathered and returns to
// gathering; the memories keep their contents but are never read before
// being written
module cubic_bspline_prefilter_row_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [cbp_pkg::SMP_W-1:0]  sample,
  output logic                              strobe,
  output logic signed [cbp_pkg::SMP_W-1:0]  coefficient,
  output logic                              last_in_row
);

  // read-out from the filter sequencer towards the output registers
  cbp_pkg::emit_t emit;

  // sequencer with the sample memory and the coefficient memory
  cbp_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (sample),
    .busy   (busy),
    .emit   (emit)
  );

  // scaling by six, rounding and saturation, then the output register
  cbp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .strobe      (strobe),
    .coefficient (coefficient),
    .last_in_row (last_in_row)
  );

  // a coefficient only ever follows a cycle in which the filter was running
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("coefficient strobed without a running row");

  // the row ends after its final coefficient
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_in_row) |=> !strobe)
    else $error("coefficient strobed right after the end of a row");

  // no new sample is taken while the read-out is still under way
  a_busy_mid_row: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_in_row) |-> busy)
    else $error("filter idle in the middle of a read-out");

endmodule
